// ----- sv/signed_mul_div_alu_defines.svh -----
// ----------------------------------------------------------------------------
// signed_mul_div_alu_defines
// Assertion macros shared by the ALU modules. They expect clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MUL_DIV_ALU_DEFINES_SVH
`define SIGNED_MUL_DIV_ALU_DEFINES_SVH

// same-cycle implication
`define SDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sda_pkg.sv -----
// ----------------------------------------------------------------------------
// sda_pkg
// Types, operation codes and width constants of the signed mul/div ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package sda_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_W           = 32;
  localparam int RES_W             = 64;
  localparam int OP_W              = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_NEG = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           req_type;
    logic signed [FIELD_W-1:0] operand_a;
    logic signed [FIELD_W-1:0] operand_b;
  } sda_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    divide_by_zero;
  } sda_out_t;

  // top -> serial core
  typedef struct packed {
    logic go;
    logic is_div;
  } sda_cmd_t;

  // serial core -> top
  typedef struct packed {
    logic busy;
    logic done;
  } sda_sts_t;

endpackage

`default_nettype wire

// ----- sv/sda_core.sv -----
// ----------------------------------------------------------------------------
// sda_core
// Radix-2 serial unit on magnitudes: shift-add multiply or restoring
// shift-subtract divide, one operand bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sda_core #(
  parameter int OPERAND_WIDTH = sda_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sda_pkg::sda_cmd_t          cmd,
  input  wire logic [OPERAND_WIDTH-1:0]   mag_a,
  input  wire logic [OPERAND_WIDTH-1:0]   mag_b,
  output sda_pkg::sda_sts_t               sts,
  output logic      [2*OPERAND_WIDTH-1:0] mag_res
);
  import sda_pkg::*;

  `include "signed_mul_div_alu_defines.svh"

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic             div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     addend_r, addend_nxt;
  logic [W-1:0]     hi_r, hi_nxt;
  logic [W-1:0]     lo_r, lo_nxt;

  logic [W:0]       mul_sum;
  logic [W:0]       div_sh;
  logic [W:0]       div_diff;
  logic             div_ge;

  always_comb begin
    mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, addend_r} : {(W+1){1'b0}});
    div_sh   = {hi_r, lo_r[W-1]};
    div_diff = div_sh - {1'b0, addend_r};
    div_ge   = !div_diff[W];
  end

  always_comb begin
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    addend_nxt = addend_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    if (cmd.go) begin
      run_nxt    = 1'b1;
      div_nxt    = cmd.is_div;
      cnt_nxt    = CNT_W'(W - 1);
      addend_nxt = cmd.is_div ? mag_b : mag_a;
      lo_nxt     = cmd.is_div ? mag_a : mag_b;
      hi_nxt     = '0;
    end else if (run_r) begin
      if (div_r) begin
        // partial remainder in hi, dividend bits leave lo as quotient bits enter
        hi_nxt = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
        lo_nxt = {lo_r[W-2:0], div_ge};
      end else begin
        hi_nxt = mul_sum[W:1];
        lo_nxt = {mul_sum[0], lo_r[W-1:1]};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    div_r    <= div_nxt;
    cnt_r    <= cnt_nxt;
    addend_r <= addend_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

  assign sts.busy = run_r;
  assign sts.done = done_r;
  assign mag_res  = div_r ? {{W{1'b0}}, lo_r} : {hi_r, lo_r};

  `SDA_ASSERT_IMP(a_go_when_idle, cmd.go, !run_r, "core started while running")
  `SDA_ASSERT_IMP(a_done_not_run, done_r, !run_r, "done while still running")
  `SDA_ASSERT_IMP(a_fell_done, $fell(run_r), done_r, "run ended without done")

endmodule

`default_nettype wire

// ----- sv/signed_mul_div_alu.sv -----
// ----------------------------------------------------------------------------
// signed_mul_div_alu: add, subtract, negate and divide by zero give their word in the cycle
// after start. Multiply and divide run the bit-serial loop in sda_core; busy is high
// meanwhile, so one such word at a time.
// Synchronous active-low reset clears busy and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_mul_div_alu #(
  parameter int OPERAND_WIDTH = sda_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sda_pkg::sda_in_t in_word,
  output logic                  out_valid,
  output sda_pkg::sda_out_t     out_word
);
  import sda_pkg::*;

  `include "signed_mul_div_alu_defines.svh"

  localparam int W = OPERAND_WIDTH;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic           state_r, state_nxt;
  logic           neg_r, neg_nxt;
  logic           out_valid_r, out_valid_nxt;
  sda_out_t       out_word_r, out_word_nxt;

  logic           accept;
  logic [W-1:0]   a_w, b_w;
  logic [W-1:0]   mag_a, mag_b;
  logic [W-1:0]   simple_w;
  logic           serial_op;
  logic [RES_W-1:0] mag_ext;

  sda_cmd_t       cmd;
  sda_sts_t       sts;
  logic [2*W-1:0] mag_res;

  assign accept = start && (state_r == ST_IDLE);
  assign a_w    = in_word.operand_a[W-1:0];
  assign b_w    = in_word.operand_b[W-1:0];
  assign mag_a  = a_w[W-1] ? ('0 - a_w) : a_w;
  assign mag_b  = b_w[W-1] ? ('0 - b_w) : b_w;

  always_comb begin
    case (in_word.req_type)
      OP_ADD:  simple_w = a_w + b_w;
      OP_SUB:  simple_w = a_w - b_w;
      OP_NEG:  simple_w = '0 - a_w;
      default: simple_w = '0;
    endcase
  end

  assign serial_op = (in_word.req_type == OP_MUL) ||
                     ((in_word.req_type == OP_DIV) && (b_w != '0));

  assign cmd.go     = accept && serial_op;
  assign cmd.is_div = (in_word.req_type == OP_DIV);

  assign mag_ext = RES_W'(mag_res);

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (serial_op) begin
            state_nxt = ST_RUN;
            neg_nxt   = a_w[W-1] ^ b_w[W-1];
          end else begin
            out_valid_nxt               = 1'b1;
            out_word_nxt.result_value   = {{(RES_W-W){simple_w[W-1]}}, simple_w};
            out_word_nxt.divide_by_zero = (in_word.req_type == OP_DIV);
          end
        end
      end
      ST_RUN: begin
        if (sts.done) begin
          // sign fix-up on the exact magnitude
          state_nxt                   = ST_IDLE;
          out_valid_nxt               = 1'b1;
          out_word_nxt.result_value   = neg_r ? ('0 - mag_ext) : mag_ext;
          out_word_nxt.divide_by_zero = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    out_word_r <= out_word_nxt;
  end

  sda_core #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .mag_a   (mag_a),
    .mag_b   (mag_b),
    .sts     (sts),
    .mag_res (mag_res)
  );

  assign busy      = (state_r == ST_RUN);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `SDA_ASSERT_NXT(a_serial_busy, cmd.go, busy && sts.busy, "serial op did not go busy")
  `SDA_ASSERT_NXT(a_done_result, busy && sts.done, out_valid && !busy, "no result after done")
  `SDA_ASSERT_NXT(a_simple_one, accept && !serial_op, out_valid && !busy, "simple op late")
  `SDA_ASSERT_IMP(a_dz_zero, out_valid && out_word.divide_by_zero,
    out_word.result_value == '0, "divide by zero with nonzero result")
  `SDA_ASSERT_IMP(a_core_in_run, sts.busy, busy, "core running outside run state")

endmodule

`default_nettype wire
